[rtl/core/ir_ac_frame_encoder_top_defines.svh]
// Assertion macros shared by the frame encoder RTL.
`ifndef IR_AC_FRAME_ENCODER_TOP_DEFINES_SVH
`define IR_AC_FRAME_ENCODER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define IRAC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IRAC_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

[rtl/core/irac_pkg.sv]
// Package with types, constants, and the checksum and mode-mapping functions of the IR encoder.
`default_nettype none
package irac_pkg;
   localparam logic [13:0] HDR_MARK_US   = 14'd9010;
   localparam logic [15:0] HDR_SPACE_US  = 16'd4505;
   localparam logic [13:0] BIT_MARK_US   = 14'd680;
   localparam logic [15:0] ONE_SPACE_US  = 16'd1530;
   localparam logic [15:0] ZERO_SPACE_US = 16'd510;
   localparam logic [15:0] GAP_SPACE_US  = 16'd19975;
   localparam logic [15:0] GAP2_SPACE_US = 16'd39950;
   localparam logic [2:0]  MARKER_BITS   = 3'b010;
   localparam logic [7:0]  BYTE3_CONST   = 8'h50;
   localparam logic [7:0]  BYTE11_CONST  = 8'h70;
   localparam logic [7:0]  FIXED_TEMP    = 8'd25;
   localparam logic [3:0]  CSUM_SEED     = 4'd10;
   localparam logic [7:0]  LAST_POS      = 8'd139;
   localparam logic [7:0]  BLOCK_PAIRS   = 8'd70;

   localparam logic [1:0] ST_PAIR = 2'd0;
   localparam logic [1:0] ST_ACC  = 2'd1;
   localparam logic [1:0] ST_REJ  = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   localparam logic [1:0] CMD_STATE  = 2'd0;
   localparam logic [1:0] CMD_TOGGLE = 2'd1;
   localparam logic [1:0] CMD_EXTRA  = 2'd2;

   localparam logic CSR_FLOOR   = 1'b0;
   localparam logic CSR_CEILING = 1'b1;

   // Classified item handed from the front to the back end.
   typedef struct packed {
      logic         advance;
      logic         ok;
      logic [127:0] frame;
   } op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] mark_us;
      logic [15:0] space_us;
      logic        last_pair;
   } rsp_type;

   function automatic logic [3:0] block_sum(input logic [63:0] b);
      logic [3:0] s;
      s = CSUM_SEED;
      for (int i = 0; i < 4; i++) s = s + b[8*i +: 4];
      for (int i = 4; i < 7; i++) s = s + b[8*i+4 +: 4];
      return s;
   endfunction

   function automatic logic [2:0] mode_field(input logic [2:0] m);
      case (m)
         3'd1:    return 3'd1;
         3'd3:    return 3'd2;
         3'd4:    return 3'd4;
         3'd5:    return 3'd3;
         default: return 3'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

[rtl/core/irac_front.sv]
// Front end: checks a load item and builds its frame, or passes an advance on.
`default_nettype none
module irac_front (
   input  wire logic [1:0] command,
   input  wire logic       operation,
   input  wire logic [2:0] mode,
   input  wire logic [2:0] fan_speed,
   input  wire logic [7:0] setpoint,
   input  wire logic [6:0] toggle_flags,
   input  wire logic [3:0] item_index,
   input  wire logic [5:0] temp_floor,
   input  wire logic [5:0] temp_ceiling,
   output irac_pkg::op_type op
);
   import irac_pkg::*;
   logic       ok, power, ion, swv, swh;
   logic [3:0] vane;
   logic [2:0] m;
   logic [1:0] fc;
   logic [7:0] t, tf;
   logic [127:0] f;

   always_comb begin
      ok = 1'b1;
      power = 1'b1;
      ion = 1'b0;
      vane = {3'd0, toggle_flags[1]};
      unique case (command)
         CMD_STATE:  ok = (mode != 3'd0) && (mode <= 3'd5);
         CMD_TOGGLE: begin
            ok = item_index <= 4'd6;
            power = item_index != 4'd0;
         end
         CMD_EXTRA: begin
            ok = item_index <= 4'd7;
            if (item_index <= 4'd4) vane = item_index + 4'd2;
            else if (item_index == 4'd5) vane = 4'd0;
            else ion = item_index == 4'd6;
         end
         default: ok = 1'b0;
      endcase
      m = (mode <= 3'd5) ? mode : 3'd2;
      fc = (fan_speed <= 3'd3) ? fan_speed[1:0] : 2'd0;
      swh = toggle_flags[2];
      swv = toggle_flags[1] || vane == 4'd1;
      t = (m == 3'd2 || m == 3'd3) ? FIXED_TEMP : setpoint;
      if (t < {2'b0, temp_floor}) t = {2'b0, temp_floor};
      if (t > {2'b0, temp_ceiling}) t = {2'b0, temp_ceiling};
      tf = t - {2'b0, temp_floor};
      f = '0;
      f[7:0] = {1'b0, swv || swh, fc, power, mode_field(m)};
      f[15:8] = {4'd0, tf[3:0]};
      f[23:16] = {toggle_flags[4] && (m == 3'd1 || m == 3'd3), ion, toggle_flags[5],
                  toggle_flags[3] && fc == 2'd0, 4'd0};
      f[31:24] = BYTE3_CONST;
      f[39:32] = {3'd0, swh, vane};
      f[63:56] = {block_sum(f[63:0]), 4'd0};
      f[71:64] = f[7:0];
      f[79:72] = f[15:8];
      f[87:80] = f[23:16];
      f[95:88] = BYTE11_CONST;
      f[103:96] = {toggle_flags[6], 7'd0};
      f[119:112] = {2'b0, fc, 4'd0};
      f[127:120] = {block_sum(f[127:64]), 4'd0};
      op.advance = operation;
      op.ok = ok;
      op.frame = f;
   end
endmodule
`default_nettype wire

[rtl/core/irac_queue.sv]
// Two-entry queue between front and back end.
`default_nettype none
module irac_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_stall,
   input  wire irac_pkg::op_type wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_take,
   output irac_pkg::op_type      rd_data
);
   import irac_pkg::*;
   `include "ir_ac_frame_encoder_top_defines.svh"
   op_type     mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr, rd;

   assign wr_stall = cnt_ff == 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign wr = wr_valid && !wr_stall;
   assign rd = rd_valid && rd_take;
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ wr;
      rp_in = rp_ff ^ rd;
      cnt_in = cnt_ff + {1'b0, wr} - {1'b0, rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   `IRAC_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `IRAC_ASSERT_IMP(a_ptr_eq, clock, reset, cnt_ff == 2'd0 || cnt_ff == 2'd2, wp_ff == rp_ff)
   `IRAC_ASSERT_NEXT(a_full_hold, clock, reset, cnt_ff == 2'd2 && !rd_take, cnt_ff == 2'd2)
endmodule
`default_nettype wire

[rtl/core/irac_back.sv]
// Back end: holds the frame, walks the pair position and registers results.
`default_nettype none
module irac_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_valid,
   output logic                  op_take,
   input  wire irac_pkg::op_type op,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output irac_pkg::rsp_type     out
);
   import irac_pkg::*;
   `include "ir_ac_frame_encoder_top_defines.svh"
   logic [127:0] frame_ff, frame_in;
   logic [7:0]   pos_ff, pos_in;
   logic         act_ff, act_in, vld_ff, vld_in;
   rsp_type      rsp_ff, rsp_in;
   logic [7:0]   q;
   logic         blk;
   logic [5:0]   bitsel;

   assign op_take = op_valid && (!vld_ff || !out_stall);
   assign out_valid = vld_ff;
   assign out = rsp_ff;

   always_comb begin
      frame_in = frame_ff;
      pos_in = pos_ff;
      act_in = act_ff;
      rsp_in = rsp_ff;
      vld_in = vld_ff && out_stall;
      blk = pos_ff >= BLOCK_PAIRS;
      q = blk ? pos_ff - BLOCK_PAIRS : pos_ff;
      bitsel = (q <= 8'd32) ? q[5:0] - 6'd1 : q[5:0] - 6'd37;
      if (op_take) begin
         vld_in = 1'b1;
         rsp_in = '0;
         if (!op.advance) begin
            if (op.ok) begin
               frame_in = op.frame;
               pos_in = 8'd0;
               act_in = 1'b1;
               rsp_in.status = ST_ACC;
            end else begin
               rsp_in.status = ST_REJ;
            end
         end else if (!act_ff) begin
            rsp_in.status = ST_NONE;
         end else begin
            rsp_in.status = ST_PAIR;
            rsp_in.mark_us = BIT_MARK_US;
            if (q == 8'd0) begin
               rsp_in.mark_us = HDR_MARK_US;
               rsp_in.space_us = HDR_SPACE_US;
            end else if (q <= 8'd32 || (q >= 8'd37 && q <= 8'd68)) begin
               rsp_in.space_us = frame_ff[{blk, (q <= 8'd32) ? 1'b0 : 1'b1, bitsel[4:0]}]
                  ? ONE_SPACE_US : ZERO_SPACE_US;
            end else if (q <= 8'd35) begin
               rsp_in.space_us = MARKER_BITS[q[1:0] - 2'd1] ? ONE_SPACE_US : ZERO_SPACE_US;
            end else if (q == 8'd36) begin
               rsp_in.space_us = GAP_SPACE_US;
            end else if (!blk) begin
               rsp_in.space_us = GAP2_SPACE_US;
            end else begin
               rsp_in.last_pair = 1'b1;
            end
            if (pos_ff == LAST_POS) begin
               pos_in = 8'd0;
               act_in = 1'b0;
            end else begin
               pos_in = pos_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         pos_ff <= 8'd0;
         act_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         pos_ff <= pos_in;
         act_ff <= act_in;
         vld_ff <= vld_in;
      end
      rsp_ff <= rsp_in;
   end

   `IRAC_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= LAST_POS)
   `IRAC_ASSERT_IMP(a_idle_pos, clock, reset, !act_ff, pos_ff == 8'd0)
   `IRAC_ASSERT_NEXT(a_last_ends, clock, reset, op_take && op.advance && act_ff &&
      pos_ff == LAST_POS, !act_ff)
endmodule
`default_nettype wire

[rtl/core/ir_ac_frame_encoder_top.sv]
// Top level of the infrared air-conditioner frame encoder.
// The req_ channel carries one beat per item: a load (req_operation low) checks a
// command and, if valid, builds a 16-byte frame; an advance asks for the next
// mark/space pair of that frame. Every beat yields exactly one rsp_ beat.
// A load answers with status accepted or rejected; an advance answers with one
// timing pair, or status "no frame" when no frame is active. A frame has 140
// pairs and the last one carries rsp_last_pair.
// Throughput is one beat per cycle while req_stall and rsp_stall stay low. A
// request is registered first in the two-entry queue after the frame builder,
// then in the registered output stage of the pair sequencer.
// The csr_ port writes temp_floor (index 0) and temp_ceiling (index 1); write
// only while no request is in flight.
// Reset is synchronous and active high; it empties the queue, clears the frame
// and position and restores the setpoint limits to 16 and 30 C.
// If the receiver holds rsp_stall, the output beat waits, the queue fills and
// req_stall rises once both queue entries are taken.
`default_nettype none
module ir_ac_frame_encoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire logic [1:0] req_command,
   input  wire logic [2:0] req_mode,
   input  wire logic [2:0] req_fan_speed,
   input  wire logic [7:0] req_setpoint,
   input  wire logic [6:0] req_toggle_flags,
   input  wire logic [3:0] req_item_index,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [13:0]     rsp_mark_us,
   output logic [15:0]     rsp_space_us,
   output logic            rsp_last_pair,
   input  wire logic       csr_write,
   input  wire logic       csr_index,
   input  wire logic [5:0] csr_data
);
   import irac_pkg::*;
   logic [5:0] floor_ff, ceil_ff;
   op_type     fop, qop;
   logic       q_valid, q_take;
   rsp_type    rsp;

   // Setpoint limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= 6'd16;
         ceil_ff <= 6'd30;
      end else if (csr_write) begin
         if (csr_index == CSR_FLOOR) floor_ff <= csr_data;
         else if (csr_index == CSR_CEILING) ceil_ff <= csr_data;
      end
   end

   irac_front u_front (
      .command(req_command), .operation(req_operation), .mode(req_mode),
      .fan_speed(req_fan_speed), .setpoint(req_setpoint),
      .toggle_flags(req_toggle_flags), .item_index(req_item_index),
      .temp_floor(floor_ff), .temp_ceiling(ceil_ff), .op(fop)
   );

   irac_queue u_queue (
      .clock(clock), .reset(reset), .wr_valid(req_valid), .wr_stall(req_stall),
      .wr_data(fop), .rd_valid(q_valid), .rd_take(q_take), .rd_data(qop)
   );

   irac_back u_back (
      .clock(clock), .reset(reset), .op_valid(q_valid), .op_take(q_take), .op(qop),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out(rsp)
   );

   assign rsp_status = rsp.status;
   assign rsp_mark_us = rsp.mark_us;
   assign rsp_space_us = rsp.space_us;
   assign rsp_last_pair = rsp.last_pair;
endmodule
`default_nettype wire
